// File: sv/rle_dec_pkg.sv
// rle_dec_pkg.sv: shared types and constants of the run-length image byte decoder
`default_nettype none

package rle_dec_pkg;

    // field and state widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LIMIT_W   = 20;
    localparam int unsigned LEN_W     = 9;
    localparam int unsigned POS_W     = 17;
    localparam int unsigned PSIZE_W   = 16;
    // position arithmetic with room for a carry out of POS_W
    localparam int unsigned POSX_W    = POS_W + 1;

    // header layout and code values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(256 * 212);
    localparam logic [POS_W-1:0]   POS_SIZE_LO   = POS_W'(3);
    localparam logic [POS_W-1:0]   POS_SIZE_HI   = POS_W'(4);
    localparam logic [POS_W-1:0]   PAYLOAD_START = POS_W'(7);
    localparam logic [BYTE_W-1:0]  CODE_LONG_RUN = BYTE_W'(8'h00);
    localparam logic [BYTE_W-1:0]  LITERAL_FLOOR = BYTE_W'(8'h10);
    localparam logic [LEN_W-1:0]   FULL_RUN      = LEN_W'(256);

    // which byte the decoder expects next
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_CODE   = 2'd1,
        PH_COUNT  = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    // one decoded run
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic              last;
    } run_t;

endpackage

`default_nettype wire

// File: sv/rle_image_byte_decoder_core.sv
// rle_image_byte_decoder_core.sv: top level of the run-length image byte decoder
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  input   | in        | in_valid / in_ready   | file_byte, start_of_file
//  output  | out       | out_valid / out_ready | run_value, run_length, last
//  config  | in        | cfg_wr_en             | cfg_wr_data (output_limit)
//
// One byte is taken per cycle while in_ready is high, set by the single state update
// per byte; the decode state updates in the cycle of the transfer and a resulting run
// is registered in the output register, or in the skid register while that is held.
// A two-entry output buffer (output register plus skid register) lets a byte be taken
// while a run still waits; in_ready drops only when both entries are full.
// rst_n clears all control state; the limit returns to 256*212 pixels.
`default_nettype none

module rle_image_byte_decoder_core
    import rle_dec_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // byte input
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  file_byte,
    input  wire logic               start_of_file,
    // run output
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [BYTE_W-1:0]       run_value,
    output logic [LEN_W-1:0]        run_length,
    output logic                    last,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

    // decode state
    logic [LIMIT_W-1:0] output_limit_reg;
    logic [POS_W-1:0]   byte_position_reg, byte_position_next;
    logic [PSIZE_W-1:0] payload_size_reg, payload_size_next;
    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   pending_count_reg, pending_count_next;
    logic [LIMIT_W-1:0] pixels_emitted_reg, pixels_emitted_next;
    logic               finished_reg, finished_next;

    // output buffer
    logic               out_valid_reg, skid_valid_reg;
    run_t               out_run_reg, skid_run_reg;

    // decode datapath
    logic               in_fire;
    logic               res_valid;
    run_t               res;
    logic [POSX_W-1:0]  pos_x;
    logic [POSX_W-1:0]  last_pos;
    logic               limit_hit;
    logic [LIMIT_W-1:0] room;
    logic [LEN_W-1:0]   rep;
    logic [LEN_W-1:0]   clip_len;
    logic [LIMIT_W-1:0] emitted_sum;
    logic               do_run;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    // position of the final payload byte and budget left
    assign pos_x     = POSX_W'(byte_position_reg);
    assign last_pos  = POSX_W'(payload_size_reg) + POSX_W'(PAYLOAD_START) - POSX_W'(1);
    assign limit_hit = pixels_emitted_reg >= output_limit_reg;
    assign room      = limit_hit ? '0 : output_limit_reg - pixels_emitted_reg;

    // run length clipped to the budget
    assign rep         = (phase_reg == PH_VALUE) ? pending_count_reg : LEN_W'(1);
    assign clip_len    = (LIMIT_W'(rep) < room) ? rep : room[LEN_W-1:0];
    assign emitted_sum = pixels_emitted_reg + LIMIT_W'(clip_len);

    // next decode state and result
    always_comb
    begin
        byte_position_next  = byte_position_reg;
        payload_size_next   = payload_size_reg;
        phase_next          = phase_reg;
        pending_count_next  = pending_count_reg;
        pixels_emitted_next = pixels_emitted_reg;
        finished_next       = finished_reg;
        res_valid           = 1'b0;
        res                 = '{value: '0, length: '0, last: 1'b1};
        do_run              = 1'b0;

        if (in_fire) begin
            if (start_of_file) begin
                byte_position_next  = POS_W'(1);
                payload_size_next   = '0;
                phase_next          = PH_HEADER;
                pending_count_next  = '0;
                pixels_emitted_next = '0;
                finished_next       = 1'b0;
            end else if (!finished_reg) begin
                byte_position_next = byte_position_reg + POS_W'(1);
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (byte_position_reg == POS_SIZE_LO) begin
                            payload_size_next = {payload_size_reg[PSIZE_W-1:BYTE_W], file_byte};
                        end else if (byte_position_reg == POS_SIZE_HI) begin
                            payload_size_next = {file_byte, payload_size_reg[BYTE_W-1:0]};
                        end else if (byte_position_reg == PAYLOAD_START - POS_W'(1)) begin
                            if (payload_size_reg == '0 || limit_hit) begin
                                res_valid     = 1'b1;
                                finished_next = 1'b1;
                            end else begin
                                phase_next = PH_CODE;
                            end
                        end
                    end
                    PH_CODE:
                    begin
                        if (limit_hit) begin
                            res_valid     = 1'b1;
                            finished_next = 1'b1;
                        end else if (file_byte == CODE_LONG_RUN) begin
                            // code, count and value must all fit in the payload
                            if (pos_x + POSX_W'(2) > last_pos) begin
                                res_valid     = 1'b1;
                                finished_next = 1'b1;
                            end else begin
                                phase_next = PH_COUNT;
                            end
                        end else if (file_byte < LITERAL_FLOOR) begin
                            if (pos_x + POSX_W'(1) > last_pos) begin
                                res_valid     = 1'b1;
                                finished_next = 1'b1;
                            end else begin
                                pending_count_next = LEN_W'(file_byte);
                                phase_next         = PH_VALUE;
                            end
                        end else begin
                            do_run = 1'b1;
                        end
                    end
                    PH_COUNT:
                    begin
                        pending_count_next = (file_byte == '0) ? FULL_RUN : LEN_W'(file_byte);
                        phase_next         = PH_VALUE;
                    end
                    PH_VALUE:
                    begin
                        phase_next = PH_CODE;
                        do_run     = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase

                // literal or completed run
                if (do_run) begin
                    res_valid           = 1'b1;
                    pixels_emitted_next = emitted_sum;
                    res.value           = file_byte;
                    res.length          = clip_len;
                    res.last            = (emitted_sum >= output_limit_reg) || (pos_x >= last_pos);
                    finished_next       = res.last;
                end
            end
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            output_limit_reg   <= LIMIT_RESET;
            byte_position_reg  <= '0;
            payload_size_reg   <= '0;
            phase_reg          <= PH_HEADER;
            pending_count_reg  <= '0;
            pixels_emitted_reg <= '0;
            finished_reg       <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                output_limit_reg <= cfg_wr_data;
            end
            byte_position_reg  <= byte_position_next;
            payload_size_reg   <= payload_size_next;
            phase_reg          <= phase_next;
            pending_count_reg  <= pending_count_next;
            pixels_emitted_reg <= pixels_emitted_next;
            finished_reg       <= finished_next;
        end
    end

    // output buffer valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg <= res_valid;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_run_reg <= skid_run_reg;
            end
        end else if (!out_valid_reg || out_ready) begin
            out_run_reg <= res;
        end else if (res_valid) begin
            skid_run_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_value  = out_run_reg.value;
    assign run_length = out_run_reg.length;
    assign last       = out_run_reg.last;

    // skid entry is only used behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // an empty run only ever closes a file
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_length == '0) |-> last)
        else $error("zero-length run without last");

    // run length never exceeds a full run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length <= FULL_RUN))
        else $error("run length out of range");

    // a closing result leaves the decoder waiting for a start byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> finished_reg)
        else $error("decoder still active after last result");

endmodule

`default_nettype wire
